@@ src/slipf_pkg.sv @@
// ============================================================================
// slipf_pkg
// Shared types and constants for the SLIP framer with transmit FIFO.
// ============================================================================
package slipf_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 64;

    // Command codes of an input item
    localparam logic [1:0] CMD_PAYLOAD = 2'd0;
    localparam logic [1:0] CMD_END     = 2'd1;
    localparam logic [1:0] CMD_TX      = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RETRY = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Sink reply codes
    localparam logic [1:0] SINK_OK    = 2'd0;
    localparam logic [1:0] SINK_RETRY = 2'd1;

    // SLIP framing bytes
    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    // Per-item result flags, fill level travels separately (width follows depth)
    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
        logic       tx_valid;
    } res_flags_t;

endpackage

@@ src/slipf_if.sv @@
// ============================================================================
// slipf_if
// Valid/ready channels: command items in, result items out.
// ============================================================================
interface slipf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [1:0] sink_status;

    modport source (output valid, cmd, data_byte, sink_status, input ready);
    modport sink   (input valid, cmd, data_byte, sink_status, output ready);
endinterface

interface slipf_out_if #(
    parameter int FILL_W = 7
);
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [1:0]        status;
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, accepted, status, tx_valid, tx_byte, fill_level,
                    input ready);
    modport sink   (input valid, accepted, status, tx_valid, tx_byte, fill_level,
                    output ready);
endinterface

@@ src/slipf_ram.sv @@
// ============================================================================
// slipf_ram
// FIFO byte store: one write port, one read port with registered data.
// ============================================================================
module slipf_ram #(
    parameter int FIFO_DEPTH = 64,
    parameter int PTR_W      = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [FIFO_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/slipf_ctrl.sv @@
// ============================================================================
// slipf_ctrl
// Framing decisions, FIFO pointers and count, owed-END flag, and the
// write sequencer that places the second and third byte of an item.
// ============================================================================
module slipf_ctrl
    import slipf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
    parameter int PTR_W      = $clog2(FIFO_DEPTH),
    parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [1:0]       cmd,
    input  logic [7:0]       data_byte,
    input  logic [1:0]       sink_status,
    output logic             busy,
    output res_flags_t       flags,
    output logic [CNT_W-1:0] fill,
    output logic             wr_en,
    output logic [PTR_W-1:0] wr_addr,
    output logic [7:0]       wr_data,
    output logic             rd_en,
    output logic [PTR_W-1:0] rd_addr
);

    localparam logic [CNT_W:0]   DEPTH_C = (CNT_W + 1)'(FIFO_DEPTH);
    localparam logic [PTR_W+1:0] DEPTH_P = (PTR_W + 2)'(FIFO_DEPTH);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             end_owed_reg, end_owed_next;
    logic [1:0]       pend_cnt_reg, pend_cnt_next;
    logic [PTR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]       pend0_reg, pend0_next;
    logic [7:0]       pend1_reg, pend1_next;

    logic             special;
    logic [7:0]       m0, m1;
    logic [1:0]       nmain;
    logic             full, owed_fits, fits;
    logic             push_owed, push_main, pop;
    logic [1:0]       npush;
    logic [7:0]       b0;
    logic [CNT_W:0]   need_sum;
    logic [PTR_W+1:0] wr_sum, wr1_sum, pend_sum, rd_sum;

    // Encoded bytes of the item itself
    always_comb
    begin
        special = (data_byte == CODE_END) || (data_byte == CODE_ESC);
        if (cmd == CMD_PAYLOAD)
        begin
            nmain = special ? 2'd2 : 2'd1;
            m0    = special ? CODE_ESC : data_byte;
            m1    = (data_byte == CODE_END) ? CODE_ESC_END : CODE_ESC_ESC;
        end
        else
        begin
            nmain = 2'd1;
            m0    = CODE_END;
            m1    = CODE_END;
        end
    end

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign owed_fits = !end_owed_reg || !full;
    assign need_sum  = {1'b0, count_reg} + (CNT_W + 1)'(end_owed_reg)
                       + (CNT_W + 1)'(nmain);
    assign fits      = (need_sum <= DEPTH_C);

    always_comb
    begin
        push_owed     = 1'b0;
        push_main     = 1'b0;
        pop           = 1'b0;
        end_owed_next = end_owed_reg;
        flags         = '{accepted: 1'b0, status: ST_OK, tx_valid: 1'b0};
        case (cmd)
            CMD_PAYLOAD, CMD_END:
            begin
                if (!owed_fits)
                begin
                    flags.status = ST_RETRY;
                end
                else
                begin
                    push_owed     = end_owed_reg;
                    end_owed_next = 1'b0;
                    if (fits)
                    begin
                        push_main      = 1'b1;
                        flags.accepted = 1'b1;
                    end
                    else
                    begin
                        flags.status = ST_RETRY;
                        if (cmd == CMD_END)
                        begin
                            end_owed_next = 1'b1;
                        end
                    end
                end
            end
            CMD_TX:
            begin
                if (count_reg != '0)
                begin
                    flags.tx_valid = 1'b1;
                    case (sink_status)
                        SINK_OK:    pop = 1'b1;
                        SINK_RETRY: flags.status = ST_RETRY;
                        default:    flags.status = ST_ERROR;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign npush = 2'(push_owed) + (push_main ? nmain : 2'd0);
    assign b0    = push_owed ? CODE_END : m0;

    // Pointer arithmetic with wrap at the FIFO depth
    always_comb
    begin
        wr_sum = {2'b00, wr_ptr_reg} + (PTR_W + 2)'(npush);
        if (wr_sum >= DEPTH_P)
        begin
            wr_sum = wr_sum - DEPTH_P;
        end
        wr1_sum = {2'b00, wr_ptr_reg} + (PTR_W + 2)'(1);
        if (wr1_sum >= DEPTH_P)
        begin
            wr1_sum = wr1_sum - DEPTH_P;
        end
        pend_sum = {2'b00, pend_addr_reg} + (PTR_W + 2)'(1);
        if (pend_sum >= DEPTH_P)
        begin
            pend_sum = pend_sum - DEPTH_P;
        end
        rd_sum = {2'b00, rd_ptr_reg} + (PTR_W + 2)'(1);
        if (rd_sum >= DEPTH_P)
        begin
            rd_sum = rd_sum - DEPTH_P;
        end
    end

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        pend_cnt_next  = pend_cnt_reg;
        pend_addr_next = pend_addr_reg;
        pend0_next     = pend0_reg;
        pend1_next     = pend1_reg;
        wr_en          = 1'b0;
        wr_addr        = wr_ptr_reg;
        wr_data        = b0;
        if (pend_cnt_reg != 2'd0)
        begin
            // Trailing bytes of the previous item, one a cycle
            wr_en          = 1'b1;
            wr_addr        = pend_addr_reg;
            wr_data        = pend0_reg;
            pend0_next     = pend1_reg;
            pend_addr_next = pend_sum[PTR_W-1:0];
            pend_cnt_next  = pend_cnt_reg - 2'd1;
        end
        else if (take)
        begin
            wr_en          = (npush != 2'd0);
            wr_ptr_next    = wr_sum[PTR_W-1:0];
            count_next     = count_reg + CNT_W'(npush) - CNT_W'(pop);
            pend_addr_next = wr1_sum[PTR_W-1:0];
            if (pop)
            begin
                rd_ptr_next = rd_sum[PTR_W-1:0];
            end
            if (push_owed && push_main)
            begin
                pend0_next    = m0;
                pend1_next    = m1;
                pend_cnt_next = nmain;
            end
            else if (push_main && nmain == 2'd2)
            begin
                pend0_next    = m1;
                pend_cnt_next = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
            end_owed_reg <= 1'b0;
            pend_cnt_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            count_reg    <= count_next;
            pend_cnt_reg <= pend_cnt_next;
            if (take)
            begin
                end_owed_reg <= end_owed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend0_reg     <= pend0_next;
        pend1_reg     <= pend1_next;
    end

    assign busy    = (pend_cnt_reg != 2'd0);
    assign fill    = count_next;
    assign rd_en   = take && (cmd == CMD_TX);
    assign rd_addr = rd_ptr_reg;

endmodule

@@ src/slip_framer_with_tx_fifo.sv @@
// ============================================================================
// slip_framer_with_tx_fifo
// SLIP byte-stuffing framer in front of a ring transmit FIFO.
// ============================================================================
// Use:
//  cmd_ch carries one command item per handshake: a payload byte to frame,
//  an end-of-packet mark, or a transmit offer carrying the sink's reply.
//  res_ch returns exactly one result item per command item, in order:
//  accepted flag, status, offered head byte and FIFO fill level.
// Pipeline: the store read and the flags register load at the accepting
//  edge, the output register loads from them when it is free or being
//  emptied; res_ch shows the result once the output register holds it.
// Throughput: one item per cycle when an item writes at most one byte and
//  res_ch keeps draining. The store has a single write port, so each
//  further byte (the second byte of an escape, an owed END placed in
//  front) is written while cmd_ch.ready is held low.
// Stalls: a two-deep result pipeline sits between the store read and res_ch,
//  so one more item is taken while a finished result waits; beyond that
//  cmd_ch.ready drops until res_ch drains.
// Reset: pointers, fill count, owed-END flag and the pipeline clear at once;
//  store contents are left as they are and are never used before written.
// ============================================================================
module slip_framer_with_tx_fifo
    import slipf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    slipf_in_if.sink   cmd_ch,
    slipf_out_if.source res_ch
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic             take;
    logic             busy;
    res_flags_t       flags;
    logic [CNT_W-1:0] fill;
    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic [7:0]       wr_data, rd_data;

    // Decision stage result, waiting for the store read
    logic             s1_valid_reg, s1_valid_next;
    res_flags_t       s1_flags_reg;
    logic [CNT_W-1:0] s1_fill_reg;
    logic             s1_adv;

    // Output register
    logic             out_valid_reg, out_valid_next;
    res_flags_t       out_flags_reg;
    logic [7:0]       out_byte_reg;
    logic [CNT_W-1:0] out_fill_reg;
    logic             out_load;

    slipf_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PTR_W      (PTR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .cmd         (cmd_ch.cmd),
        .data_byte   (cmd_ch.data_byte),
        .sink_status (cmd_ch.sink_status),
        .busy        (busy),
        .flags       (flags),
        .fill        (fill),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    slipf_ram #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PTR_W      (PTR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // s1 moves on whenever the output register is free or being emptied
    assign s1_adv       = !out_valid_reg || res_ch.ready;
    assign cmd_ch.ready = !busy && (!s1_valid_reg || s1_adv);
    assign take         = cmd_ch.valid && cmd_ch.ready;
    assign out_load     = s1_valid_reg && s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_flags_reg <= flags;
            s1_fill_reg  <= fill;
        end
        if (out_load)
        begin
            out_flags_reg <= s1_flags_reg;
            out_fill_reg  <= s1_fill_reg;
            // store read data is only meaningful for an offer
            out_byte_reg  <= s1_flags_reg.tx_valid ? rd_data : 8'h00;
        end
    end

    assign res_ch.valid      = out_valid_reg;
    assign res_ch.accepted   = out_flags_reg.accepted;
    assign res_ch.status     = out_flags_reg.status;
    assign res_ch.tx_valid   = out_flags_reg.tx_valid;
    assign res_ch.tx_byte    = out_byte_reg;
    assign res_ch.fill_level = out_fill_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= CNT_W'(FIFO_DEPTH))
        else $error("fill count beyond FIFO depth");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !res_ch.ready |=> s1_valid_reg)
        else $error("pending result dropped under stall");

    a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.accepted |-> res_ch.status == ST_OK && !res_ch.tx_valid)
        else $error("accepted result with bad status or offer");
`endif

endmodule
